// ===== rtl/ssia_pkg.sv =====
// ----------------------------------------------------------------------------
// ssia_pkg: shared constants of the sky source image accumulator
// Operation and source codes, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
package ssia_pkg;

  // Default image edge length in pixels.
  localparam int unsigned DefImageSize = 256;

  // Reset value of the pixel size register, 1.0 in unsigned Q16.16.
  localparam logic [31:0] PixelSizeRst = 32'h0001_0000;

  // Operation codes of an item.
  localparam logic [1:0] ModeAdd   = 2'd0;
  localparam logic [1:0] ModeRead  = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;
  localparam logic [1:0] ModeNop   = 2'd3;

  // Source kinds.
  localparam logic [1:0] KindGauss = 2'd0;
  localparam logic [1:0] KindDisk  = 2'd1;
  localparam logic [1:0] KindOther = 2'd2;

  // ln(2) and 1.0 in Q30, and the number of series terms for 2^-f.
  localparam logic [29:0] Ln2Q30    = 30'd744261118;
  localparam logic [30:0] OneQ30    = 31'h4000_0000;
  localparam logic [3:0]  TermCount = 4'd12;

  // Largest shift that still leaves a nonzero Gaussian term.
  localparam logic [6:0] MaxExpInt = 7'd32;

endpackage

// ===== rtl/sky_source_image_accumulator.sv =====
// ----------------------------------------------------------------------------
// sky_source_image_accumulator: sky source image accumulator
// Adds point, Gaussian and disk sources into a square Q16.16 pixel store,
// reads single pixels and clears the store.
// ----------------------------------------------------------------------------
//  channel | ports                                    | handshake
//  --------+------------------------------------------+------------------------
//  item    | mode_i, source_kind_i, amplitude_i,      | start & !busy
//          | source_radius_i, x/y_offset_i, read_*_i  |
//  result  | pixel_value_o, status_o                  | done_o, one cycle
//  config  | cfg_wdata_i (pixel size)                 | cfg_we_i
//
// An add first runs two (point) or four (box) 38-step divisions, then walks
// the box one pixel at a time; a Gaussian pixel uses the shared bit-serial
// divider (two 52-step quotients and twelve 31-step series divisions) and
// the shared multiplier. After reset a clearing pass over all
// IMAGE_SIZE*IMAGE_SIZE pixels runs with busy high. The result receiver
// cannot stall; done_o marks each result.
// ----------------------------------------------------------------------------
module sky_source_image_accumulator #(
  parameter int unsigned IMAGE_SIZE = ssia_pkg::DefImageSize
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [1:0]  source_kind_i,
  input  logic signed [31:0] amplitude_i,
  input  logic [31:0] source_radius_i,
  input  logic signed [31:0] x_offset_i,
  input  logic signed [31:0] y_offset_i,
  input  logic [7:0]  read_row_i,
  input  logic [7:0]  read_col_i,
  output logic        done_o,
  output logic signed [31:0] pixel_value_o,
  output logic        status_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned Depth = IMAGE_SIZE * IMAGE_SIZE;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(IMAGE_SIZE + 1);
  localparam int unsigned Ctr   = IMAGE_SIZE / 2;

  localparam logic [AW-1:0]        ImgA    = AW'(IMAGE_SIZE);
  localparam logic [AW-1:0]        LastA   = AW'(Depth - 1);
  localparam logic signed [CW:0]   CtrS    = (CW+1)'(Ctr);
  localparam logic signed [39:0]   CtrL    = 40'(Ctr);
  localparam logic signed [39:0]   SizeL   = 40'(IMAGE_SIZE);
  localparam logic [CW-1:0]        SizeC   = CW'(IMAGE_SIZE);
  localparam logic [15:0]          Size16  = 16'(IMAGE_SIZE);

  typedef enum logic [29:0] {
    ST_IDLE    = 30'b1 << 0,
    ST_CLEAR   = 30'b1 << 1,
    ST_RD      = 30'b1 << 2,
    ST_RD_DATA = 30'b1 << 3,
    ST_FIN     = 30'b1 << 4,
    ST_DIV     = 30'b1 << 5,
    ST_BOX_ISS = 30'b1 << 6,
    ST_BOX_GET = 30'b1 << 7,
    ST_BOX_CHK = 30'b1 << 8,
    ST_ROW     = 30'b1 << 9,
    ST_ROW_P   = 30'b1 << 10,
    ST_COL     = 30'b1 << 11,
    ST_COL_P   = 30'b1 << 12,
    ST_G_QY    = 30'b1 << 13,
    ST_G_SQ1   = 30'b1 << 14,
    ST_G_SQ2   = 30'b1 << 15,
    ST_G_T     = 30'b1 << 16,
    ST_G_F     = 30'b1 << 17,
    ST_G_U     = 30'b1 << 18,
    ST_G_TM    = 30'b1 << 19,
    ST_G_AC    = 30'b1 << 20,
    ST_G_E     = 30'b1 << 21,
    ST_G_V1    = 30'b1 << 22,
    ST_G_V2    = 30'b1 << 23,
    ST_D_Y     = 30'b1 << 24,
    ST_D_R     = 30'b1 << 25,
    ST_D_CMP   = 30'b1 << 26,
    ST_RMW_RD  = 30'b1 << 27,
    ST_RMW_WR  = 30'b1 << 28,
    ST_NEXT    = 30'b1 << 29
  } state_e;

  state_e state_q, state_d;
  state_e div_ret_q, div_ret_d;

  logic [31:0] pix_size_q;
  logic [AW-1:0] clr_q, clr_d;
  logic clr_cmd_q, clr_cmd_d;

  // Latched item and derived values.
  logic [31:0] s_q, s_d, r_q, r_d;
  logic [34:0] r6_q, r6_d;
  logic [35:0] b_q, b_d;
  logic signed [31:0] amp_q, amp_d, xo_q, xo_d, yo_q, yo_d;
  logic [1:0] kind_q, kind_d, bq_q, bq_d;
  logic pt_q, pt_d, rd_ok_q, rd_ok_d, numneg_q, numneg_d;

  // Box coordinates and walk position.
  logic signed [39:0] ri0_q, ri0_d, ri1_q, ri1_d, rj0_q, rj0_d, rj1_q, rj1_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, i1_q, i1_d, j0_q, j0_d, j1_q, j1_d;

  // Per-pixel working values.
  logic [47:0] ux_q, ux_d, uy_q, uy_d;
  logic [18:0] qx_q, qx_d, qy_q, qy_d;
  logic [64:0] sq_q, sq_d;
  logic [6:0]  n_q, n_d;
  logic [29:0] u_q, u_d;
  logic [3:0]  k_q, k_d;
  logic signed [32:0] acc_q, acc_d, v_q, v_d;
  logic [62:0] mag_q, mag_d;

  // Shared multiplier.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  // Shared bit-serial divider.
  logic [51:0] div_quo_q, div_quo_d;
  logic [31:0] div_rem_q, div_rem_d, div_den_q, div_den_d;
  logic [5:0]  div_cnt_q, div_cnt_d;
  logic        div_go;
  logic [51:0] div_dvd;
  logic [31:0] div_dvs;
  logic [5:0]  div_n;
  state_e      div_rt;

  // Results.
  logic done_q, done_d;
  logic signed [31:0] res_val_q, res_val_d;
  logic res_st_q, res_st_d;

  // RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, pix_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic accept;

  function automatic logic [CW-1:0] clamp_crd(logic signed [39:0] x);
    logic [CW-1:0] c;
    if (x < 40'sd0) begin
      c = '0;
    end else if (x > SizeL) begin
      c = SizeC;
    end else begin
      c = x[CW-1:0];
    end
    return c;
  endfunction

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign done_o        = done_q;
  assign pixel_value_o = res_val_q;
  assign status_o      = res_st_q;

  assign pix_addr = AW'(i_q) * ImgA + AW'(j_q);

  ssia_ram #(
    .WIDTH(32),
    .DEPTH(Depth)
  ) u_image (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(pix_addr),
    .rdata_o(ram_rdata)
  );

  // Combinational helpers used by several states.
  logic signed [CW:0]  di, dj;
  logic signed [47:0]  dxy;
  logic [47:0]         adxy;
  logic signed [37:0]  num;
  logic [37:0]         num_mag;
  logic [32:0]         rem2;
  logic                rnd_up;
  logic [38:0]         qr;
  logic signed [39:0]  coord;
  logic signed [32:0]  amp_x, amag;
  logic [30:0]         term, e_val;
  logic [5:0]          sh;
  logic [62:0]         cval;
  logic signed [33:0]  sat_sum;
  logic signed [31:0]  sat_val;
  logic [CW-1:0]       i0c, i1c, j0c, j1c, jn, in_;
  logic [32:0]         rem_sh;
  logic                div_ge;
  logic [32:0]         rem_sub;

  always_comb begin
    di = $signed({1'b0, i_q}) - CtrS;
    dj = $signed({1'b0, j_q}) - CtrS;
    if (state_q == ST_ROW_P) begin
      dxy = $signed(prod_q[47:0]) - 48'(xo_q);
    end else begin
      dxy = $signed(prod_q[47:0]) - 48'(yo_q);
    end
    adxy = dxy[47] ? 48'(-dxy) : 48'(dxy);

    // Rounding division operand for the box edges.
    case (bq_q)
      2'd0:    num = 38'(xo_q) - $signed({2'b00, b_q});
      2'd1:    num = 38'(xo_q) + $signed({2'b00, b_q});
      2'd2:    num = 38'(yo_q) - $signed({2'b00, b_q});
      default: num = 38'(yo_q) + $signed({2'b00, b_q});
    endcase
    num_mag = num[37] ? 38'(-num) : 38'(num);

    // Quotient rounded to nearest, ties to even, then moved to the center.
    rem2   = {div_rem_q, 1'b0};
    rnd_up = (rem2 > {1'b0, s_q}) || ((rem2 == {1'b0, s_q}) && div_quo_q[0]);
    qr     = {1'b0, div_quo_q[37:0]} + 39'(rnd_up);
    coord  = numneg_q ? (CtrL - $signed({1'b0, qr})) : (CtrL + $signed({1'b0, qr}));

    amp_x = {amp_q[31], amp_q};
    amag  = amp_x[32] ? -amp_x : amp_x;
    term  = div_quo_q[30:0];

    if (acc_q < 33'sd0) begin
      e_val = '0;
    end else if (acc_q > $signed({2'b00, ssia_pkg::OneQ30})) begin
      e_val = ssia_pkg::OneQ30;
    end else begin
      e_val = acc_q[30:0];
    end
    sh   = 6'd30 + n_q[5:0];
    cval = mag_q >> sh;

    sat_sum = 34'($signed(ram_rdata)) + 34'(v_q);
    if (sat_sum > 34'sd2147483647) begin
      sat_val = 32'sh7FFF_FFFF;
    end else if (sat_sum < -34'sd2147483648) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = sat_sum[31:0];
    end

    i0c = clamp_crd(ri0_q);
    i1c = clamp_crd(ri1_q);
    j0c = clamp_crd(rj0_q);
    j1c = clamp_crd(rj1_q);
    jn  = j_q + CW'(1);
    in_ = i_q + CW'(1);

    // One restoring division step.
    rem_sh  = {div_rem_q, div_quo_q[51]};
    div_ge  = rem_sh >= {1'b0, div_den_q};
    rem_sub = rem_sh - {1'b0, div_den_q};
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d   = state_q;
    div_ret_d = div_ret_q;
    clr_d     = clr_q;
    clr_cmd_d = clr_cmd_q;
    s_d = s_q;  r_d = r_q;  r6_d = r6_q;  b_d = b_q;
    amp_d = amp_q;  xo_d = xo_q;  yo_d = yo_q;
    kind_d = kind_q;  bq_d = bq_q;  pt_d = pt_q;
    rd_ok_d = rd_ok_q;  numneg_d = numneg_q;
    ri0_d = ri0_q;  ri1_d = ri1_q;  rj0_d = rj0_q;  rj1_d = rj1_q;
    i_d = i_q;  j_d = j_q;  i1_d = i1_q;  j0_d = j0_q;  j1_d = j1_q;
    ux_d = ux_q;  uy_d = uy_q;  qx_d = qx_q;  qy_d = qy_q;
    sq_d = sq_q;  n_d = n_q;  u_d = u_q;  k_d = k_q;
    acc_d = acc_q;  v_d = v_q;  mag_d = mag_q;
    div_quo_d = div_quo_q;  div_rem_d = div_rem_q;
    div_den_d = div_den_q;  div_cnt_d = div_cnt_q;
    res_val_d = res_val_q;  res_st_d = res_st_q;
    done_d    = 1'b0;
    mul_a = '0;  mul_b = '0;
    div_go = 1'b0;  div_dvd = '0;  div_dvs = '0;  div_n = '0;  div_rt = ST_IDLE;
    ram_we = 1'b0;  ram_waddr = pix_addr;  ram_wdata = sat_val;

    case (state_q)
      // Wait for an item and latch it.
      ST_IDLE: begin
        if (accept) begin
          s_d    = (pix_size_q == '0) ? 32'd1 : pix_size_q;
          r_d    = source_radius_i;
          r6_d   = {1'b0, source_radius_i, 2'b00} + {2'b00, source_radius_i, 1'b0};
          amp_d  = amplitude_i;
          xo_d   = x_offset_i;
          yo_d   = y_offset_i;
          kind_d = source_kind_i;
          pt_d   = (source_radius_i == '0);
          bq_d   = 2'd0;
          if (source_radius_i == '0) begin
            b_d = '0;
          end else if (source_kind_i == ssia_pkg::KindGauss) begin
            b_d = {1'b0, source_radius_i, 3'b000};
          end else begin
            b_d = {3'b000, source_radius_i, 1'b0};
          end
          rd_ok_d   = ({8'd0, read_row_i} < Size16) && ({8'd0, read_col_i} < Size16);
          i_d       = CW'(read_row_i);
          j_d       = CW'(read_col_i);
          res_val_d = '0;
          res_st_d  = 1'b0;
          case (mode_i)
            ssia_pkg::ModeAdd: begin
              if (source_radius_i != '0 && source_kind_i != ssia_pkg::KindGauss &&
                  source_kind_i != ssia_pkg::KindDisk) begin
                state_d = ST_FIN;
              end else begin
                state_d = ST_BOX_ISS;
              end
            end
            ssia_pkg::ModeRead: begin
              state_d = ST_RD;
            end
            ssia_pkg::ModeClear: begin
              clr_d     = '0;
              clr_cmd_d = 1'b1;
              state_d   = ST_CLEAR;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end

      // Zero the store one pixel per cycle.
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastA) begin
          state_d = clr_cmd_q ? ST_FIN : ST_IDLE;
        end
      end

      // Single pixel read.
      ST_RD: begin
        state_d = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        res_val_d = rd_ok_q ? $signed(ram_rdata) : 32'sd0;
        state_d   = ST_FIN;
      end

      // Present the result.
      ST_FIN: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      // Divider iterations; return when the count runs out.
      ST_DIV: begin
        div_rem_d = div_ge ? rem_sub[31:0] : rem_sh[31:0];
        div_quo_d = {div_quo_q[50:0], div_ge};
        div_cnt_d = div_cnt_q - 6'd1;
        if (div_cnt_q == 6'd1) begin
          state_d = div_ret_q;
        end
      end

      // Box edges, or the point position, as rounded pixel coordinates.
      ST_BOX_ISS: begin
        numneg_d = num[37];
        div_go   = 1'b1;
        div_dvd  = {num_mag, 14'd0};
        div_dvs  = s_q;
        div_n    = 6'd38;
        div_rt   = ST_BOX_GET;
      end
      ST_BOX_GET: begin
        case (bq_q)
          2'd0:    ri0_d = coord;
          2'd1:    ri1_d = coord;
          2'd2:    rj0_d = coord;
          default: rj1_d = coord;
        endcase
        if (bq_q == 2'd3 || (pt_q && bq_q == 2'd2)) begin
          state_d = ST_BOX_CHK;
        end else begin
          bq_d    = pt_q ? bq_q + 2'd2 : bq_q + 2'd1;
          state_d = ST_BOX_ISS;
        end
      end
      ST_BOX_CHK: begin
        if (pt_q) begin
          if (ri0_q < 40'sd0 || ri0_q >= SizeL || rj0_q < 40'sd0 || rj0_q >= SizeL) begin
            res_st_d = 1'b1;
            state_d  = ST_FIN;
          end else begin
            i_d     = ri0_q[CW-1:0];
            j_d     = rj0_q[CW-1:0];
            v_d     = amp_x;
            state_d = ST_RMW_RD;
          end
        end else if (i0c >= i1c || j0c >= j1c) begin
          state_d = ST_FIN;
        end else begin
          i_d     = i0c;
          i1_d    = i1c;
          j_d     = j0c;
          j0_d    = j0c;
          j1_d    = j1c;
          state_d = ST_ROW;
        end
      end

      // Row distance from the source.
      ST_ROW: begin
        mul_a   = $signed({1'b0, s_q});
        mul_b   = 33'(di);
        state_d = ST_ROW_P;
      end
      ST_ROW_P: begin
        ux_d    = adxy;
        state_d = ST_COL;
      end

      // Column distance and choice of the pixel's work.
      ST_COL: begin
        mul_a   = $signed({1'b0, s_q});
        mul_b   = 33'(dj);
        state_d = ST_COL_P;
      end
      ST_COL_P: begin
        uy_d = adxy;
        if (kind_q == ssia_pkg::KindGauss) begin
          if (ux_q >= 48'(r6_q) || adxy >= 48'(r6_q)) begin
            state_d = ST_NEXT;
          end else begin
            div_go  = 1'b1;
            div_dvd = {ux_q[35:0], 16'd0};
            div_dvs = r_q;
            div_n   = 6'd52;
            div_rt  = ST_G_QY;
          end
        end else begin
          mul_a = $signed({1'b0, ux_q[31:0]});
          mul_b = $signed({1'b0, ux_q[31:0]});
          if (ux_q > 48'(r_q) || adxy > 48'(r_q)) begin
            state_d = ST_NEXT;
          end else begin
            state_d = ST_D_Y;
          end
        end
      end

      // Gaussian: normalized distances, squared and summed.
      ST_G_QY: begin
        qx_d    = div_quo_q[18:0];
        div_go  = 1'b1;
        div_dvd = {uy_q[35:0], 16'd0};
        div_dvs = r_q;
        div_n   = 6'd52;
        div_rt  = ST_G_SQ1;
      end
      ST_G_SQ1: begin
        qy_d    = div_quo_q[18:0];
        mul_a   = $signed({14'd0, qx_q});
        mul_b   = $signed({14'd0, qx_q});
        state_d = ST_G_SQ2;
      end
      ST_G_SQ2: begin
        sq_d    = prod_q[64:0];
        mul_a   = $signed({14'd0, qy_q});
        mul_b   = $signed({14'd0, qy_q});
        state_d = ST_G_T;
      end
      ST_G_T: begin
        sq_d    = sq_q + prod_q[64:0];
        n_d     = sq_d[38:32];
        state_d = ST_G_F;
      end

      // Gaussian: 2^-f as a series for exp(-f*ln2).
      ST_G_F: begin
        mul_a   = $signed({17'd0, sq_q[31:16]});
        mul_b   = $signed({3'd0, ssia_pkg::Ln2Q30});
        state_d = ST_G_U;
      end
      ST_G_U: begin
        u_d     = prod_q[45:16];
        k_d     = 4'd1;
        acc_d   = $signed({2'b00, ssia_pkg::OneQ30});
        mul_a   = $signed({2'b00, ssia_pkg::OneQ30});
        mul_b   = $signed({3'd0, prod_q[45:16]});
        state_d = ST_G_TM;
      end
      ST_G_TM: begin
        div_go  = 1'b1;
        div_dvd = {prod_q[60:30], 21'd0};
        div_dvs = {28'd0, k_q};
        div_n   = 6'd31;
        div_rt  = ST_G_AC;
      end
      ST_G_AC: begin
        if (k_q[0]) begin
          acc_d = acc_q - $signed({2'b00, term});
        end else begin
          acc_d = acc_q + $signed({2'b00, term});
        end
        mul_a = $signed({2'b00, term});
        mul_b = $signed({3'd0, u_q});
        if (k_q == ssia_pkg::TermCount) begin
          state_d = ST_G_E;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = ST_G_TM;
        end
      end

      // Gaussian: scale the amplitude and round.
      ST_G_E: begin
        mul_a = amag;
        mul_b = $signed({2'b00, e_val});
        if (n_q > ssia_pkg::MaxExpInt) begin
          state_d = ST_NEXT;
        end else begin
          state_d = ST_G_V1;
        end
      end
      ST_G_V1: begin
        mag_d   = prod_q[62:0] + (63'd1 << (sh - 6'd1));
        state_d = ST_G_V2;
      end
      ST_G_V2: begin
        if (cval == '0) begin
          state_d = ST_NEXT;
        end else begin
          v_d     = amp_q[31] ? -$signed(cval[32:0]) : $signed(cval[32:0]);
          state_d = ST_RMW_RD;
        end
      end

      // Disk: inside test on squared distances.
      ST_D_Y: begin
        sq_d    = prod_q[64:0];
        mul_a   = $signed({1'b0, uy_q[31:0]});
        mul_b   = $signed({1'b0, uy_q[31:0]});
        state_d = ST_D_R;
      end
      ST_D_R: begin
        sq_d    = sq_q + prod_q[64:0];
        mul_a   = $signed({1'b0, r_q});
        mul_b   = $signed({1'b0, r_q});
        state_d = ST_D_CMP;
      end
      ST_D_CMP: begin
        if (sq_q <= prod_q[64:0]) begin
          v_d     = amp_x;
          state_d = ST_RMW_RD;
        end else begin
          state_d = ST_NEXT;
        end
      end

      // Saturating read-modify-write of one pixel.
      ST_RMW_RD: begin
        state_d = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        ram_we  = 1'b1;
        state_d = ST_NEXT;
      end

      // Advance over the box.
      ST_NEXT: begin
        if (pt_q) begin
          state_d = ST_FIN;
        end else if (jn != j1_q) begin
          j_d     = jn;
          state_d = ST_COL;
        end else if (in_ != i1_q) begin
          i_d     = in_;
          j_d     = j0_q;
          state_d = ST_ROW;
        end else begin
          state_d = ST_FIN;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Divider launch.
    if (div_go) begin
      div_quo_d = div_dvd;
      div_rem_d = '0;
      div_den_d = div_dvs;
      div_cnt_d = div_n;
      div_ret_d = div_rt;
      state_d   = ST_DIV;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      div_ret_q  <= ST_IDLE;
      clr_q      <= '0;
      clr_cmd_q  <= 1'b0;
      done_q     <= 1'b0;
      pix_size_q <= ssia_pkg::PixelSizeRst;
      div_cnt_q  <= '0;
    end else begin
      state_q   <= state_d;
      div_ret_q <= div_ret_d;
      clr_q     <= clr_d;
      clr_cmd_q <= clr_cmd_d;
      done_q    <= done_d;
      div_cnt_q <= div_cnt_d;
      if (cfg_we_i) begin
        pix_size_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    s_q <= s_d;  r_q <= r_d;  r6_q <= r6_d;  b_q <= b_d;
    amp_q <= amp_d;  xo_q <= xo_d;  yo_q <= yo_d;
    kind_q <= kind_d;  bq_q <= bq_d;  pt_q <= pt_d;
    rd_ok_q <= rd_ok_d;  numneg_q <= numneg_d;
    ri0_q <= ri0_d;  ri1_q <= ri1_d;  rj0_q <= rj0_d;  rj1_q <= rj1_d;
    i_q <= i_d;  j_q <= j_d;  i1_q <= i1_d;  j0_q <= j0_d;  j1_q <= j1_d;
    ux_q <= ux_d;  uy_q <= uy_d;  qx_q <= qx_d;  qy_q <= qy_d;
    sq_q <= sq_d;  n_q <= n_d;  u_q <= u_d;  k_q <= k_d;
    acc_q <= acc_d;  v_q <= v_d;  mag_q <= mag_d;
    div_quo_q <= div_quo_d;  div_rem_q <= div_rem_d;  div_den_q <= div_den_d;
    res_val_q <= res_val_d;  res_st_q <= res_st_d;
    prod_q <= mul_a * mul_b;
  end

endmodule

// ===== rtl/ssia_ram.sv =====
// ----------------------------------------------------------------------------
// ssia_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ssia_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
